FILE: rtl/rba_pkg.sv
// Shared types, constants and sample-window geometry for the ROI brightness accumulator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package rba_pkg;

    // Default configuration of the block.
    localparam int DEF_NUM_DIGITS         = 4;
    localparam int DEF_SEGMENTS_PER_DIGIT = 8;
    localparam int DEF_ACC_WIDTH          = 32;
    localparam int QUEUE_DEPTH            = 2;

    // Fixed field widths.
    localparam int COORD_W  = 12;
    localparam int COLOR_W  = 16;
    localparam int SEL_W    = 6;
    localparam int RADIUS_W = 3;
    localparam int BRIGHT_W = 10;
    localparam int CENTRE_W = 9;
    localparam int OUT_W    = 32;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd1;

    // Indicator LED window centre.
    localparam logic [CENTRE_W-1:0] LED_CX = 9'd315;
    localparam logic [CENTRE_W-1:0] LED_CY = 9'd320;

    // Segment sample points known for the display.
    localparam int TBL_DIGITS = 4;
    localparam int TBL_SEGS   = 8;

    localparam logic [CENTRE_W-1:0] SEG_CX [TBL_DIGITS][TBL_SEGS] = '{
        '{9'd0,   9'd327, 9'd326, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd334, 9'd338, 9'd336, 9'd332, 9'd329, 9'd331, 9'd333, 9'd0},
        '{9'd349, 9'd353, 9'd351, 9'd347, 9'd345, 9'd345, 9'd348, 9'd0},
        '{9'd359, 9'd363, 9'd361, 9'd357, 9'd354, 9'd355, 9'd358, 9'd0}
    };

    localparam logic [CENTRE_W-1:0] SEG_CY [TBL_DIGITS][TBL_SEGS] = '{
        '{9'd0,   9'd322, 9'd329, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd318, 9'd322, 9'd330, 9'd333, 9'd330, 9'd321, 9'd326, 9'd0},
        '{9'd319, 9'd323, 9'd330, 9'd333, 9'd330, 9'd323, 9'd326, 9'd0},
        '{9'd320, 9'd323, 9'd331, 9'd334, 9'd330, 9'd323, 9'd327, 9'd0}
    };

    localparam logic [TBL_SEGS-1:0] SEG_OK [TBL_DIGITS] = '{
        8'b0000_0110,
        8'b0111_1111,
        8'b0111_1111,
        8'b0111_1111
    };

    typedef enum logic {
        CMD_ACC  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                ok;
        logic [CENTRE_W-1:0] cx;
        logic [CENTRE_W-1:0] cy;
    } t_centre;

    // Classified word as it travels from the front end to the back end.
    typedef struct packed {
        t_cmd                cmd;
        logic [SEL_W-1:0]    sel;
        logic [BRIGHT_W-1:0] bright;
    } t_q_head;

    function automatic t_centre led_centre();
        t_centre c;
        c.ok = 1'b1;
        c.cx = LED_CX;
        c.cy = LED_CY;
        return c;
    endfunction

    // Digits and segments outside the known layout have no sample point.
    function automatic t_centre seg_centre(int d, int s);
        t_centre c;
        c = '0;
        if (d < TBL_DIGITS && s < TBL_SEGS) begin
            c.ok = SEG_OK[d][s];
            c.cx = SEG_CX[d][s];
            c.cy = SEG_CY[d][s];
        end
        return c;
    endfunction

endpackage

FILE: rtl/rba_front.sv
// Front end: converts RGB565 to brightness and classifies each word into a window mask.
// Uses rba_pkg for the window geometry and the queued word layout.
`timescale 1ns / 1ps

module rba_front
    import rba_pkg::*;
#(
    parameter int NUM_DIGITS         = DEF_NUM_DIGITS,
    parameter int SEGMENTS_PER_DIGIT = DEF_SEGMENTS_PER_DIGIT,
    parameter int NWIN               = 1 + NUM_DIGITS * SEGMENTS_PER_DIGIT
) (
    input  logic                i_cmd,
    input  logic [COORD_W-1:0]  i_pixel_x,
    input  logic [COORD_W-1:0]  i_pixel_y,
    input  logic [COLOR_W-1:0]  i_pixel_color,
    input  logic [SEL_W-1:0]    i_read_window,
    input  logic [RADIUS_W-1:0] i_radius,
    output t_q_head             o_head,
    output logic [NWIN-1:0]     o_mask
);

    localparam int CMPW = ($clog2(NWIN) > SEL_W) ? $clog2(NWIN) : SEL_W;
    localparam int AW   = COORD_W + 1;

    t_cmd cmd;

    // A window whose low corner falls below zero on either axis is skipped.
    function automatic logic win_hit(t_centre c, logic [COORD_W-1:0] px,
                                     logic [COORD_W-1:0] py, logic [RADIUS_W-1:0] r);
        logic [AW-1:0] cx;
        logic [AW-1:0] cy;
        logic [AW-1:0] x;
        logic [AW-1:0] y;
        logic [AW-1:0] rr;
        cx = AW'(c.cx);
        cy = AW'(c.cy);
        x  = AW'(px);
        y  = AW'(py);
        rr = AW'(r);
        return c.ok && (cx >= rr) && (cy >= rr)
            && (x + rr >= cx) && (x <= cx + rr)
            && (y + rr >= cy) && (y <= cy + rr);
    endfunction

    assign cmd = t_cmd'(i_cmd);

    always_comb begin
        o_head.cmd    = cmd;
        o_head.sel    = i_read_window;
        o_head.bright = BRIGHT_W'({i_pixel_color[15:11], 3'b000})
                      + BRIGHT_W'({i_pixel_color[10:5], 2'b00})
                      + BRIGHT_W'({i_pixel_color[4:0], 3'b000});
    end

    // For a read the mask carries the selected window one-hot instead of the hits.
    assign o_mask[0] = (cmd == CMD_READ) ? (CMPW'(i_read_window) == CMPW'(0))
                                         : win_hit(led_centre(), i_pixel_x, i_pixel_y, i_radius);

    for (genvar d = 0; d < NUM_DIGITS; d++) begin : g_digit
        for (genvar s = 0; s < SEGMENTS_PER_DIGIT; s++) begin : g_seg
            localparam int      W = 1 + d * SEGMENTS_PER_DIGIT + s;
            localparam t_centre C = seg_centre(d, s);
            assign o_mask[W] = (cmd == CMD_READ)
                ? (CMPW'(i_read_window) == CMPW'(W))
                : win_hit(C, i_pixel_x, i_pixel_y, i_radius);
        end
    end

endmodule

FILE: rtl/rba_queue.sv
// Short FIFO that decouples the front end from the accumulator back end.
// Generic data width; uses rba_pkg only for its default depth.
`timescale 1ns / 1ps

module rba_queue
    import rba_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue holds more words than its depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

FILE: rtl/rba_back.sv
// Back end: per-window saturating accumulators and the registered read-out stage.
// Consumes classified words from rba_queue; uses rba_pkg types and widths.
`timescale 1ns / 1ps

module rba_back
    import rba_pkg::*;
#(
    parameter int ACC_WIDTH = DEF_ACC_WIDTH,
    parameter int NWIN      = 1 + DEF_NUM_DIGITS * DEF_SEGMENTS_PER_DIGIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_q_head             i_q_head,
    input  logic [NWIN-1:0]     i_q_mask,
    output logic                o_q_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SEL_W-1:0]    o_window_id,
    output logic [OUT_W-1:0]    o_brightness_sum,
    output logic [OUT_W-1:0]    o_pixel_count
);

    logic [ACC_WIDTH-1:0] r_sum [NWIN];
    logic [ACC_WIDTH-1:0] r_cnt [1:NWIN-1];
    logic                 acc_en;
    logic                 rd_en;
    logic [ACC_WIDTH-1:0] rd_sum;
    logic [ACC_WIDTH-1:0] rd_cnt;

    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [SEL_W-1:0]     r_out_id;
    logic [OUT_W-1:0]     r_out_sum;
    logic [OUT_W-1:0]     r_out_cnt;

    // Accumulate words never wait; a read waits only for room in the output register.
    assign o_q_pop = i_q_valid
                  && ((i_q_head.cmd == CMD_ACC) || !r_out_valid || !i_stall);
    assign acc_en  = o_q_pop && (i_q_head.cmd == CMD_ACC);
    assign rd_en   = o_q_pop && (i_q_head.cmd == CMD_READ);

    for (genvar w = 0; w < NWIN; w++) begin : g_sum
        logic [ACC_WIDTH:0]   wide;
        logic [ACC_WIDTH-1:0] n_sum;
        assign wide  = {1'b0, r_sum[w]} + (ACC_WIDTH + 1)'(i_q_head.bright);
        assign n_sum = wide[ACC_WIDTH] ? '1 : wide[ACC_WIDTH-1:0];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[w] <= '0;
            end else if (acc_en && i_q_mask[w]) begin
                r_sum[w] <= n_sum;
            end
        end
    end

    for (genvar w = 1; w < NWIN; w++) begin : g_cnt
        logic [ACC_WIDTH-1:0] n_cnt;
        assign n_cnt = (&r_cnt[w]) ? r_cnt[w] : r_cnt[w] + 1'b1;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[w] <= '0;
            end else if (acc_en && i_q_mask[w]) begin
                r_cnt[w] <= n_cnt;
            end
        end
    end

    // The mask is one-hot for a read, or empty when the window does not exist.
    always_comb begin
        rd_sum = '0;
        rd_cnt = '0;
        for (int w = 0; w < NWIN; w++) begin
            if (i_q_mask[w]) begin
                rd_sum = rd_sum | r_sum[w];
            end
        end
        for (int w = 1; w < NWIN; w++) begin
            if (i_q_mask[w]) begin
                rd_cnt = rd_cnt | r_cnt[w];
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (rd_en) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_out_id  <= i_q_head.sel;
            r_out_sum <= OUT_W'(rd_sum);
            r_out_cnt <= OUT_W'(rd_cnt);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_window_id      = r_out_id;
    assign o_brightness_sum = r_out_sum;
    assign o_pixel_count    = r_out_cnt;

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_out_valid && (r_out_id == $past(i_q_head.sel))))
        else $error("read word did not load the output register");

    a_acc_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_en && !r_out_valid) |=> !r_out_valid)
        else $error("accumulate word produced a result");

endmodule

FILE: rtl/roi_brightness_accumulator.sv
// An accumulate word updates the window totals when the back end pops it from the queue;
// a read word loads its result into the registered output stage when it is popped.
// Throughput: one word per cycle while o_stall is low, set by the per-window accumulator lanes.
// A two-entry queue between classification and accumulation absorbs output stalls.
// Reset clears all sums, counts, the queue and the output valid flag, and sets the radius to 1.
// Top level of the ROI brightness accumulator; depends on rba_pkg and all rba_* modules.
`timescale 1ns / 1ps

module roi_brightness_accumulator
    import rba_pkg::*;
#(
    parameter int NUM_DIGITS         = DEF_NUM_DIGITS,
    parameter int SEGMENTS_PER_DIGIT = DEF_SEGMENTS_PER_DIGIT,
    parameter int ACC_WIDTH          = DEF_ACC_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RADIUS_W-1:0] i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_cmd,
    input  logic [COORD_W-1:0]  i_pixel_x,
    input  logic [COORD_W-1:0]  i_pixel_y,
    input  logic [COLOR_W-1:0]  i_pixel_color,
    input  logic [SEL_W-1:0]    i_read_window,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SEL_W-1:0]    o_window_id,
    output logic [OUT_W-1:0]    o_brightness_sum,
    output logic [OUT_W-1:0]    o_pixel_count
);

    localparam int NWIN = 1 + NUM_DIGITS * SEGMENTS_PER_DIGIT;
    localparam int HW   = $bits(t_q_head);
    localparam int QW   = HW + NWIN;

    logic [RADIUS_W-1:0] r_radius;
    t_q_head             f_head;
    logic [NWIN-1:0]     f_mask;
    logic                q_push;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic [QW-1:0]       q_rdata;
    t_q_head             q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    rba_front #(
        .NUM_DIGITS         (NUM_DIGITS),
        .SEGMENTS_PER_DIGIT (SEGMENTS_PER_DIGIT),
        .NWIN               (NWIN)
    ) u_front (
        .i_cmd         (i_cmd),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pixel_color (i_pixel_color),
        .i_read_window (i_read_window),
        .i_radius      (r_radius),
        .o_head        (f_head),
        .o_mask        (f_mask)
    );

    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full;

    rba_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata ({f_head, f_mask}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    assign q_head = t_q_head'(q_rdata[QW-1 -: HW]);

    rba_back #(
        .ACC_WIDTH (ACC_WIDTH),
        .NWIN      (NWIN)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_head         (q_head),
        .i_q_mask         (q_rdata[NWIN-1:0]),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_window_id      (o_window_id),
        .o_brightness_sum (o_brightness_sum),
        .o_pixel_count    (o_pixel_count)
    );

endmodule

FILE: tb/sv/tb_roi_brightness_accumulator.sv
// Self-checking testbench for roi_brightness_accumulator: a directed table, then random pixel and
// read words over several radius settings, each read checked against the table's totals or a predictor.
// Depends on rba_pkg and the roi_brightness_accumulator RTL.
`timescale 1ns / 1ps

module tb_roi_brightness_accumulator;
    import rba_pkg::*;

    localparam int NUM_WIN      = 33;
    localparam int PHASE_WORDS  = 144;
    localparam int SETTLE_TICKS = 10;

    typedef struct packed {
        t_cmd               cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic [SEL_W-1:0]   sel;
    } t_pix_word;

    typedef struct packed {
        logic [SEL_W-1:0] id;
        logic [OUT_W-1:0] sum;
        logic [OUT_W-1:0] cnt;
    } t_window_totals;

    typedef struct packed {
        t_pix_word      word;
        logic           typed;
        t_window_totals totals;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RADIUS_W-1:0] i_cfg_wdata;
    logic                i_valid;
    logic                o_stall;
    logic                i_cmd;
    logic [COORD_W-1:0]  i_pixel_x;
    logic [COORD_W-1:0]  i_pixel_y;
    logic [COLOR_W-1:0]  i_pixel_color;
    logic [SEL_W-1:0]    i_read_window;
    logic                o_valid;
    logic                i_stall;
    logic [SEL_W-1:0]    o_window_id;
    logic [OUT_W-1:0]    o_brightness_sum;
    logic [OUT_W-1:0]    o_pixel_count;

    roi_brightness_accumulator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .i_pixel_color    (i_pixel_color),
        .i_read_window    (i_read_window),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_window_id      (o_window_id),
        .o_brightness_sum (o_brightness_sum),
        .o_pixel_count    (o_pixel_count)
    );

    // Predicted window state.
    logic [OUT_W-1:0]    win_sum [NUM_WIN];
    logic [OUT_W-1:0]    seg_cnt [NUM_WIN-1];
    int                  win_cx  [NUM_WIN];
    int                  win_cy  [NUM_WIN];
    bit                  win_ok  [NUM_WIN];
    logic [RADIUS_W-1:0] radius_now;

    t_window_totals pending_totals [$];
    int             mismatch_count;
    int             send_idle_pct;
    int             recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("roi_brightness_accumulator regression: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic clear_totals();
        int wi;
        // Window 0 is the indicator LED, then digit*8+segment+1; a zero centre has no sample point.
        win_cx = '{315, 0, 327, 326, 0, 0, 0, 0, 0,
                   334, 338, 336, 332, 329, 331, 333, 0,
                   349, 353, 351, 347, 345, 345, 348, 0,
                   359, 363, 361, 357, 354, 355, 358, 0};
        win_cy = '{320, 0, 322, 329, 0, 0, 0, 0, 0,
                   318, 322, 330, 333, 330, 321, 326, 0,
                   319, 323, 330, 333, 330, 323, 326, 0,
                   320, 323, 331, 334, 330, 323, 327, 0};
        for (wi = 0; wi < NUM_WIN; wi++) begin
            win_ok[wi]  = (win_cx[wi] != 0);
            win_sum[wi] = '0;
            if (wi > 0) seg_cnt[wi-1] = '0;
        end
        radius_now = RADIUS_RESET;
    endtask

    function automatic logic [OUT_W-1:0] sat_add(logic [OUT_W-1:0] a, int b);
        if (longint'(a) + longint'(b) > longint'(32'hFFFF_FFFF)) return '1;
        return a + OUT_W'(b);
    endfunction

    // Updates the predicted totals for one accepted word; a read yields the totals it reports.
    task automatic apply_word(input t_pix_word w, output bit has_result,
                              output t_window_totals t);
        int wi;
        int r;
        int px;
        int py;
        int bright;
        r  = int'(radius_now);
        px = int'(w.x);
        py = int'(w.y);
        has_result = 1'b0;
        t = '0;
        if (w.cmd == CMD_ACC) begin
            bright = int'(w.color[15:11]) * 8 + int'(w.color[10:5]) * 4
                   + int'(w.color[4:0]) * 8;
            for (wi = 0; wi < NUM_WIN; wi++) begin
                if (win_ok[wi] && win_cx[wi] >= r && win_cy[wi] >= r
                        && px + r >= win_cx[wi] && px <= win_cx[wi] + r
                        && py + r >= win_cy[wi] && py <= win_cy[wi] + r) begin
                    win_sum[wi] = sat_add(win_sum[wi], bright);
                    if (wi > 0) seg_cnt[wi-1] = sat_add(seg_cnt[wi-1], 1);
                end
            end
        end else begin
            has_result = 1'b1;
            t.id = w.sel;
            if (int'(w.sel) < NUM_WIN) begin
                t.sum = win_sum[w.sel];
                if (w.sel > 0) t.cnt = seg_cnt[w.sel - 1];
            end
        end
    endtask

    // Entered at a falling edge; returns at a falling edge after the word and any idle gap.
    task automatic send_word(input t_pix_word w, input bit typed, input t_window_totals typed_t);
        bit             has_result;
        t_window_totals t;
        i_valid       = 1'b1;
        i_cmd         = w.cmd;
        i_pixel_x     = w.x;
        i_pixel_y     = w.y;
        i_pixel_color = w.color;
        i_read_window = w.sel;
        do @(posedge i_clk); while (o_stall);
        apply_word(w, has_result, t);
        if (has_result) pending_totals.push_back(typed ? typed_t : t);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_totals.size() != 0) @(negedge i_clk);
        // Accumulate words can still be in flight after the last read has come out.
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_radius(input logic [RADIUS_W-1:0] r);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = r;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        radius_now  = r;
    endtask

    function automatic t_dir_row mk_row(t_cmd cmd, int x, int y, int color, int sel,
                                        bit typed, longint sum, longint cnt);
        t_dir_row row;
        row.word.cmd   = cmd;
        row.word.x     = COORD_W'(x);
        row.word.y     = COORD_W'(y);
        row.word.color = COLOR_W'(color);
        row.word.sel   = SEL_W'(sel);
        row.typed      = typed;
        row.totals.id  = SEL_W'(sel);
        row.totals.sum = OUT_W'(sum);
        row.totals.cnt = OUT_W'(cnt);
        return row;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_window_totals want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_totals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: window %0d sum %0d count %0d",
                             o_window_id, o_brightness_sum, o_pixel_count);
            end else begin
                want = pending_totals.pop_front();
                if (o_window_id != want.id || o_brightness_sum != want.sum
                        || o_pixel_count != want.cnt) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: window %0d/%0d sum %0d/%0d count %0d/%0d %s",
                                 want.id, o_window_id, want.sum, o_brightness_sum,
                                 want.cnt, o_pixel_count, "(expected/actual)");
                end
            end
        end
    end

    initial begin
        t_dir_row       rows [$];
        t_pix_word      w;
        t_window_totals none;
        logic [RADIUS_W-1:0] radius_plan [8];
        int p;
        int k;
        int wi;
        int px;
        int py;
        int pick;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_cmd          = 1'b0;
        i_pixel_x      = '0;
        i_pixel_y      = '0;
        i_pixel_color  = '0;
        i_read_window  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        none           = '0;
        radius_plan    = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd6, 3'd4, 3'd1};
        clear_totals();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words, all at the reset radius of 1.
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  0, 1, 0, 0));
        rows.push_back(mk_row(CMD_READ, 4095, 4095, 16'hFFFF, 32, 1, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000, 63, 1, 0, 0));
        rows.push_back(mk_row(CMD_ACC,   315,  320, 16'hFFFF,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  0, 1, 748, 0));
        rows.push_back(mk_row(CMD_ACC,   327,  322, 16'h0000, 63, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  2, 1, 0, 1));
        rows.push_back(mk_row(CMD_ACC,  4095, 4095, 16'hFFFF, 63, 0, 0, 0));
        rows.push_back(mk_row(CMD_ACC,     0,    0, 16'hFFFF,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ACC,   328,  323, 16'hF800,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ACC,   329,  322, 16'h07E0,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  2, 1, 248, 2));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  1, 1, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  8, 1, 0, 0));
        rows.push_back(mk_row(CMD_ACC,   314,  319, 16'h001F,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_ACC,   316,  321, 16'h0000,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000,  0, 1, 996, 0));
        rows.push_back(mk_row(CMD_ACC,   333,  326, 16'hFFFF,  0, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000, 15, 0, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000, 33, 1, 0, 0));
        rows.push_back(mk_row(CMD_READ,    0,    0, 16'h0000, 31, 0, 0, 0));
        foreach (rows[k]) send_word(rows[k].word, rows[k].typed, rows[k].totals);
        i_valid = 1'b0;

        for (p = 0; p < 8; p++) begin
            wait_drained();
            write_radius(radius_plan[p]);
            send_idle_pct  = (p % 4 == 1) ? 73 : (p % 4 == 3) ? 32 : 0;
            recv_stall_pct = (p % 4 == 2) ? 73 : (p % 4 == 3) ? 32 : 0;
            for (k = 0; k < PHASE_WORDS; k++) begin
                if (p == 1 && k == PHASE_WORDS / 2) begin
                    // Hold the sender off until every pending read has come out.
                    i_valid = 1'b0;
                    while (pending_totals.size() != 0) @(negedge i_clk);
                end
                w.cmd   = ($urandom_range(0, 99) < 30) ? CMD_READ : CMD_ACC;
                w.sel   = ($urandom_range(0, 99) < 85) ? SEL_W'($urandom_range(0, 32))
                                                      : SEL_W'($urandom_range(33, 63));
                w.color = ($urandom_range(0, 99) < 5) ? 16'hFFFF
                                                     : COLOR_W'($urandom_range(0, 65535));
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    wi = $urandom_range(0, NUM_WIN - 1);
                    px = win_cx[wi] + int'($urandom_range(0, 16)) - 8;
                    py = win_cy[wi] + int'($urandom_range(0, 16)) - 8;
                    if (px < 0) px = 0;
                    if (py < 0) py = 0;
                end else if (pick < 88) begin
                    px = $urandom_range(300, 380);
                    py = $urandom_range(305, 350);
                end else begin
                    px = $urandom_range(0, 4095);
                    py = $urandom_range(0, 4095);
                end
                w.x = COORD_W'(px);
                w.y = COORD_W'(py);
                send_word(w, 1'b0, none);
            end
            i_valid = 1'b0;
        end

        wait_drained();
        if (mismatch_count == 0 && pending_totals.size() == 0) begin
            $display("roi_brightness_accumulator regression: pass");
        end else begin
            $display("roi_brightness_accumulator regression: fail");
        end
        $finish;
    end

endmodule
